>>> hdl/tbi_pkg.sv
// Shared types, constants and the sine table of the turtle branch interpreter.
`default_nettype none
package tbi_pkg;

   localparam int STACK_DEPTH = 1024;
   localparam int SP_BITS     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int COORD_BITS  = 12;
   localparam int WIDTH_BITS  = 16;
   localparam int HEAD_BITS   = 13;
   localparam int LEN_BITS    = 16;
   localparam int TRIG_BITS   = 16;
   localparam int IDX_BITS    = 11;

   localparam logic [HEAD_BITS-1:0] FULL_TURN    = 13'd5760;
   localparam logic [HEAD_BITS-1:0] QUARTER_TURN = 13'd1440;
   localparam logic [HEAD_BITS-1:0] HALF_TURN    = 13'd2880;
   localparam logic [HEAD_BITS-1:0] TQ_TURN      = 13'd4320;

   localparam logic [7:0] SYM_DRAW  = 8'h46;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_PUSH  = 8'h5B;
   localparam logic [7:0] SYM_POP   = 8'h5D;

   localparam logic [1:0] KIND_SEGMENT   = 2'd0;
   localparam logic [1:0] KIND_OVERFLOW  = 2'd1;
   localparam logic [1:0] KIND_UNDERFLOW = 2'd2;

   localparam logic [2:0] REG_ANGLE_STEP  = 3'd0;
   localparam logic [2:0] REG_START_ANGLE = 3'd1;
   localparam logic [2:0] REG_STEP_LENGTH = 3'd2;
   localparam logic [2:0] REG_START_X     = 3'd3;
   localparam logic [2:0] REG_START_Y     = 3'd4;
   localparam logic [2:0] REG_WIDTH_START = 3'd5;
   localparam logic [2:0] REG_WIDTH_DEC   = 3'd6;
   localparam logic [2:0] REG_WIDTH_MIN   = 3'd7;

   typedef enum logic [2:0] {
      OP_NONE, OP_DRAW, OP_PLUS, OP_MINUS, OP_PUSH, OP_POP
   } op_type;

   typedef struct packed {
      op_type op;
      logic   new_word;
   } cmd_type;

   typedef struct packed {
      logic [HEAD_BITS-1:0]  angle_step;
      logic [HEAD_BITS-1:0]  start_angle;
      logic [LEN_BITS-1:0]   step_length;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [WIDTH_BITS-1:0] width_start;
      logic [WIDTH_BITS-1:0] width_decrement;
      logic [WIDTH_BITS-1:0] width_min;
   } cfg_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [HEAD_BITS-1:0]  heading;
      logic [WIDTH_BITS-1:0] width;
   } turtle_type;

   typedef logic [TRIG_BITS-1:0] sin_rom_type [0:1440];

   // Quarter-wave sine in Q1.15, evaluated once at elaboration from a
   // truncated integer Taylor series in Q2.30.
   function automatic sin_rom_type build_sin_rom();
      sin_rom_type       rom;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint            sum;
      for (int t = 0; t <= 1440; t++) begin
         x    = (longint'(t) * 64'd3373259426) / 64'd2880;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int k = 1; k <= 6; k++) begin
            term = (term * x2) >> 30;
            // Divide by (2k)(2k+1) for the current term.
            case (k)
               1:       term = term / 64'd6;
               2:       term = term / 64'd20;
               3:       term = term / 64'd42;
               4:       term = term / 64'd72;
               5:       term = term / 64'd110;
               default: term = term / 64'd156;
            endcase
            if (k % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         sum = (sum + 16384) >>> 15;
         if (sum > 32768) sum = 32768;
         rom[t] = sum[TRIG_BITS-1:0];
      end
      return rom;
   endfunction

   localparam sin_rom_type SIN_ROM = build_sin_rom();

endpackage
`default_nettype wire

>>> hdl/turtle_branch_interpreter.sv
// Top level of the turtle branch interpreter: configuration registers and the two halves.
`default_nettype none
// Interprets one L-system symbol per request and emits line segments or stack errors.
// A decoded request waits in a two-entry queue; the executing half takes it when idle and,
// for a draw, push or pop, the result register is free. Turns, pushes and ignored symbols
// finish on being taken; a pop then loads the stack memory read in S_POP, and a draw reads
// the sine table, multiplies in S_MUL and rounds and clamps in S_FIN; until then no symbol is taken.
// The stack memory has no clearing pass; the first symbol of every word must carry new_word.
module turtle_branch_interpreter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // symbol[7:0]
   input  wire logic        req_tuser,   // new_word
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // x_from, y_from, x_to, y_to, stroke_width
   output logic [1:0]       rsp_tuser,   // kind
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   tbi_pkg::cfg_type cfg_ff;
   logic             q_valid, q_pop;
   tbi_pkg::cmd_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_step      <= 13'd480;
         cfg_ff.start_angle     <= 13'd0;
         cfg_ff.step_length     <= 16'd614;
         cfg_ff.start_x         <= 12'd520;
         cfg_ff.start_y         <= 12'd999;
         cfg_ff.width_start     <= 16'd600;
         cfg_ff.width_decrement <= 16'd4;
         cfg_ff.width_min       <= 16'd120;
      end else if (csr_we) begin
         unique case (csr_index)
            tbi_pkg::REG_ANGLE_STEP:  cfg_ff.angle_step      <= csr_wdata[12:0];
            tbi_pkg::REG_START_ANGLE: cfg_ff.start_angle     <= csr_wdata[12:0];
            tbi_pkg::REG_STEP_LENGTH: cfg_ff.step_length     <= csr_wdata;
            tbi_pkg::REG_START_X:     cfg_ff.start_x         <= csr_wdata[11:0];
            tbi_pkg::REG_START_Y:     cfg_ff.start_y         <= csr_wdata[11:0];
            tbi_pkg::REG_WIDTH_START: cfg_ff.width_start     <= csr_wdata;
            tbi_pkg::REG_WIDTH_DEC:   cfg_ff.width_decrement <= csr_wdata;
            tbi_pkg::REG_WIDTH_MIN:   cfg_ff.width_min       <= csr_wdata;
            default: ;
         endcase
      end
   end

   tbi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop)
   );

   tbi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

>>> hdl/tbi_front.sv
// Front end: decodes request symbols and queues them for the back end.
`default_nettype none
module tbi_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [7:0]      req_tdata,
   input  wire logic            req_tuser,
   output logic                 q_valid,
   output tbi_pkg::cmd_type     q_data,
   input  wire logic            q_pop
);

   tbi_pkg::cmd_type slot_ff [0:1];
   logic [1:0]       count_ff, count_in;
   logic             rd_ff, rd_in, wr_ff, wr_in;
   tbi_pkg::cmd_type cmd;
   logic             push;

   always_comb begin
      cmd.new_word = req_tuser;
      unique case (req_tdata)
         tbi_pkg::SYM_DRAW:  cmd.op = tbi_pkg::OP_DRAW;
         tbi_pkg::SYM_PLUS:  cmd.op = tbi_pkg::OP_PLUS;
         tbi_pkg::SYM_MINUS: cmd.op = tbi_pkg::OP_MINUS;
         tbi_pkg::SYM_PUSH:  cmd.op = tbi_pkg::OP_PUSH;
         tbi_pkg::SYM_POP:   cmd.op = tbi_pkg::OP_POP;
         default:            cmd.op = tbi_pkg::OP_NONE;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   // Ignored symbols without a word start change nothing and are dropped here.
   assign push    = req_tvalid && req_tready && (cmd.op != tbi_pkg::OP_NONE || cmd.new_word);
   assign q_valid = (count_ff != 2'd0);
   assign q_data  = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
      rd_in    = rd_ff ^ q_pop;
      wr_in    = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= cmd;
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/tbi_back.sv
// Back end: turtle state, stack memory, segment arithmetic and result register.
`default_nettype none
module tbi_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tbi_pkg::cfg_type cfg,
   input  wire logic             q_valid,
   input  wire tbi_pkg::cmd_type q_data,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [63:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   localparam int CB = tbi_pkg::COORD_BITS;
   localparam int SB = tbi_pkg::SP_BITS;
   localparam int HB = tbi_pkg::HEAD_BITS;
   localparam int WB = tbi_pkg::WIDTH_BITS;
   localparam int TB = tbi_pkg::TRIG_BITS;
   localparam int PB = TB + tbi_pkg::LEN_BITS;
   localparam int OB = PB - 23;
   localparam int EB = CB + 2;

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_FIN, S_POP} state_type;

   state_type            state_ff;
   tbi_pkg::turtle_type  top_ff;
   logic [SB-1:0]        sp_ff;
   logic                 halted_ff;
   logic [TB-1:0]        cos_ff, sin_ff;
   logic                 cos_neg_ff, sin_neg_ff;
   logic [PB-1:0]        mx_ff, my_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           kind_ff;
   logic [CB-1:0]        xf_ff, yf_ff, xt_ff, yt_ff;
   logic [WB-1:0]        sw_ff;

   tbi_pkg::turtle_type  stack_mem [0:tbi_pkg::STACK_DEPTH-1];
   tbi_pkg::turtle_type  mem_rd_ff;
   logic [SB-1:0]        rd_addr;
   logic                 mem_we;

   tbi_pkg::turtle_type  eff;
   logic [SB-1:0]        eff_sp;
   logic                 eff_halt;
   logic                 needs_out, out_free, take;
   logic [HB:0]          h_start, h_sum;
   logic [HB-1:0]        turn, h_plus, h_minus, h_cos;
   logic [HB:0]          h_cos_sum;
   logic [tbi_pkg::IDX_BITS:0] sin_sel, cos_sel;
   logic [PB-1:0]        rx, ry;
   logic [OB-1:0]        off_x, off_y;
   logic signed [EB-1:0] ex, ey;
   logic [CB-1:0]        cx, cy;

   // Quadrant folding of a heading onto the quarter-wave table: {negate, index}.
   function automatic logic [tbi_pkg::IDX_BITS:0] fold(input logic [HB-1:0] h);
      logic [HB-1:0] r;
      logic [1:0]    q;
      logic [HB-1:0] idx;
      if (h >= tbi_pkg::TQ_TURN) begin
         q = 2'd3; r = h - tbi_pkg::TQ_TURN;
      end else if (h >= tbi_pkg::HALF_TURN) begin
         q = 2'd2; r = h - tbi_pkg::HALF_TURN;
      end else if (h >= tbi_pkg::QUARTER_TURN) begin
         q = 2'd1; r = h - tbi_pkg::QUARTER_TURN;
      end else begin
         q = 2'd0; r = h;
      end
      idx = q[0] ? (tbi_pkg::QUARTER_TURN - r) : r;
      return {q[1], idx[tbi_pkg::IDX_BITS-1:0]};
   endfunction

   function automatic logic [CB-1:0] clamp(input logic signed [EB-1:0] v);
      if (v < 0)                                     return '0;
      else if (v > $signed({2'b00, {CB{1'b1}}}))     return {CB{1'b1}};
      else                                           return v[CB-1:0];
   endfunction

   always_comb begin
      h_start = {1'b0, tbi_pkg::TQ_TURN} + {cfg.start_angle[HB-1], cfg.start_angle};
      if (h_start >= {1'b0, tbi_pkg::FULL_TURN}) h_start = h_start - {1'b0, tbi_pkg::FULL_TURN};
      if (q_data.new_word) begin
         eff.x       = cfg.start_x;
         eff.y       = cfg.start_y;
         eff.heading = h_start[HB-1:0];
         eff.width   = cfg.width_start;
         eff_sp      = '0;
         eff_halt    = 1'b0;
      end else begin
         eff      = top_ff;
         eff_sp   = sp_ff;
         eff_halt = halted_ff;
      end

      turn    = (cfg.angle_step >= tbi_pkg::FULL_TURN) ?
                cfg.angle_step - tbi_pkg::FULL_TURN : cfg.angle_step;
      h_sum   = {1'b0, eff.heading} + {1'b0, turn};
      h_plus  = (h_sum >= {1'b0, tbi_pkg::FULL_TURN}) ?
                HB'(h_sum - {1'b0, tbi_pkg::FULL_TURN}) : h_sum[HB-1:0];
      h_sum   = {1'b0, eff.heading} + {1'b0, tbi_pkg::FULL_TURN} - {1'b0, turn};
      h_minus = (h_sum >= {1'b0, tbi_pkg::FULL_TURN}) ?
                HB'(h_sum - {1'b0, tbi_pkg::FULL_TURN}) : h_sum[HB-1:0];

      h_cos_sum = {1'b0, eff.heading} + {1'b0, tbi_pkg::QUARTER_TURN};
      h_cos     = (h_cos_sum >= {1'b0, tbi_pkg::FULL_TURN}) ?
                  HB'(h_cos_sum - {1'b0, tbi_pkg::FULL_TURN}) : h_cos_sum[HB-1:0];
      sin_sel   = fold(eff.heading);
      cos_sel   = fold(h_cos);

      needs_out = (q_data.op == tbi_pkg::OP_DRAW) || (q_data.op == tbi_pkg::OP_PUSH) ||
                  (q_data.op == tbi_pkg::OP_POP);
      out_free  = !rsp_valid_ff || rsp_tready;
      take      = (state_ff == S_IDLE) && q_valid && (!needs_out || out_free);
      mem_we    = take && !eff_halt && (q_data.op == tbi_pkg::OP_PUSH) &&
                  (eff_sp != SB'(tbi_pkg::STACK_DEPTH - 1));
      rd_addr   = eff_sp - 1'b1;

      // Round half away from zero, then reapply the sign of the trig value.
      rx    = mx_ff + PB'(32'd4194304);
      ry    = my_ff + PB'(32'd4194304);
      off_x = rx[PB-1:23];
      off_y = ry[PB-1:23];
      ex    = cos_neg_ff ? $signed({2'b00, top_ff.x}) - $signed({{(EB-OB){1'b0}}, off_x})
                         : $signed({2'b00, top_ff.x}) + $signed({{(EB-OB){1'b0}}, off_x});
      ey    = sin_neg_ff ? $signed({2'b00, top_ff.y}) - $signed({{(EB-OB){1'b0}}, off_y})
                         : $signed({2'b00, top_ff.y}) + $signed({{(EB-OB){1'b0}}, off_y});
      cx    = clamp(ex);
      cy    = clamp(ey);
   end

   assign q_pop      = take;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {sw_ff, yt_ff, xt_ff, yf_ff, xf_ff};
   assign rsp_tuser  = kind_ff;

   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[eff_sp] <= eff;
      mem_rd_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (take) begin
                  top_ff    <= eff;
                  sp_ff     <= eff_sp;
                  halted_ff <= eff_halt;
                  if (!eff_halt) begin
                     case (q_data.op)
                        tbi_pkg::OP_DRAW: begin
                           sin_ff     <= tbi_pkg::SIN_ROM[sin_sel[tbi_pkg::IDX_BITS-1:0]];
                           cos_ff     <= tbi_pkg::SIN_ROM[cos_sel[tbi_pkg::IDX_BITS-1:0]];
                           sin_neg_ff <= sin_sel[tbi_pkg::IDX_BITS];
                           cos_neg_ff <= cos_sel[tbi_pkg::IDX_BITS];
                           state_ff   <= S_MUL;
                        end
                        tbi_pkg::OP_PLUS:  top_ff.heading <= h_plus;
                        tbi_pkg::OP_MINUS: top_ff.heading <= h_minus;
                        tbi_pkg::OP_PUSH: begin
                           if (eff_sp == SB'(tbi_pkg::STACK_DEPTH - 1)) begin
                              halted_ff    <= 1'b1;
                              rsp_valid_ff <= 1'b1;
                              kind_ff      <= tbi_pkg::KIND_OVERFLOW;
                              {xf_ff, yf_ff, xt_ff, yt_ff, sw_ff} <= '0;
                           end else begin
                              sp_ff <= eff_sp + 1'b1;
                           end
                        end
                        tbi_pkg::OP_POP: begin
                           if (eff_sp == '0) begin
                              halted_ff    <= 1'b1;
                              rsp_valid_ff <= 1'b1;
                              kind_ff      <= tbi_pkg::KIND_UNDERFLOW;
                              {xf_ff, yf_ff, xt_ff, yt_ff, sw_ff} <= '0;
                           end else begin
                              state_ff <= S_POP;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
            S_MUL: begin
               mx_ff    <= PB'(cos_ff) * PB'(cfg.step_length);
               my_ff    <= PB'(sin_ff) * PB'(cfg.step_length);
               state_ff <= S_FIN;
            end
            S_FIN: begin
               rsp_valid_ff <= 1'b1;
               kind_ff      <= tbi_pkg::KIND_SEGMENT;
               xf_ff        <= top_ff.x;
               yf_ff        <= top_ff.y;
               xt_ff        <= cx;
               yt_ff        <= cy;
               sw_ff        <= (top_ff.width > cfg.width_min) ? top_ff.width : cfg.width_min;
               top_ff.x     <= cx;
               top_ff.y     <= cy;
               top_ff.width <= (top_ff.width > cfg.width_decrement) ?
                               top_ff.width - cfg.width_decrement : '0;
               state_ff     <= S_IDLE;
            end
            S_POP: begin
               top_ff   <= mem_rd_ff;
               sp_ff    <= sp_ff - 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != tbi_pkg::KIND_SEGMENT |-> rsp_tdata == '0)
      else $error("error result carries nonzero payload");

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SB'(tbi_pkg::STACK_DEPTH - 1))
      else $error("stack pointer beyond stack depth");

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !q_pop)
      else $error("request taken while a previous one is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_tdata))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> tb/sv/turtle_branch_interpreter_tb.sv
// Self-checking testbench of the turtle branch interpreter.
module turtle_branch_interpreter_tb;
   import tbi_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 24;

   typedef struct {
      logic [1:0]  kind;
      logic [11:0] x_from;
      logic [11:0] y_from;
      logic [11:0] x_to;
      logic [11:0] y_to;
      logic [15:0] stroke;
   } segment_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   turtle_branch_interpreter uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Predictor state: registers and the turtle stack.
   cfg_type     regs;
   logic [11:0] turtle_x [0:STACK_DEPTH-1];
   logic [11:0] turtle_y [0:STACK_DEPTH-1];
   int unsigned turtle_head [0:STACK_DEPTH-1];
   int unsigned turtle_wid [0:STACK_DEPTH-1];
   int unsigned depth_ptr = 0;
   bit          stopped = 0;

   segment_type pending_segments [$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          stalls_on = 1;

   // Quarter-wave sine in Q1.15 from a truncated Taylor series in Q2.30.
   function automatic int unsigned quarter_sine(int unsigned t);
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned part;
      longint          acc;
      ang = (longint'(t) * 64'd3373259426) / 64'd2880;
      ang_sq = (ang * ang) >> 30;
      part = ang;
      acc = longint'(ang);
      for (int k = 1; k <= 6; k++) begin
         part = ((part * ang_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
         acc = (k % 2 == 1) ? acc - longint'(part) : acc + longint'(part);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 16384) >>> 15;
      if (acc > 32768) acc = 32768;
      return int'(acc);
   endfunction

   function automatic int signed_sine(int unsigned h);
      int unsigned quad;
      int unsigned rem;
      int          v;
      quad = (h / 1440) % 4;
      rem = h % 1440;
      v = int'(quarter_sine(quad[0] ? 1440 - rem : rem));
      return quad[1] ? -v : v;
   endfunction

   function automatic int moved_coord(int base, int trig, int unsigned len);
      longint unsigned mag;
      longint          off;
      mag = (trig < 0) ? longint'(-trig) : longint'(trig);
      off = longint'((mag * len + 64'd4194304) >> 23);
      off = (trig < 0) ? base - off : base + off;
      if (off < 0) return 0;
      if (off > 4095) return 4095;
      return int'(off);
   endfunction

   task automatic predict_symbol(input logic [7:0] sym, input logic fresh);
      segment_type seg;
      int unsigned turn;
      int unsigned h;
      int          start_h;
      turn = regs.angle_step % 5760;
      seg = '{KIND_SEGMENT, 0, 0, 0, 0, 0};
      if (fresh) begin
         start_h = (4320 + int'($signed(regs.start_angle))) % 5760;
         if (start_h < 0) start_h += 5760;
         depth_ptr = 0;
         stopped = 0;
         turtle_x[0] = regs.start_x;
         turtle_y[0] = regs.start_y;
         turtle_head[0] = start_h;
         turtle_wid[0] = regs.width_start;
      end
      if (!stopped) begin
         case (sym)
            SYM_DRAW: begin
               h = turtle_head[depth_ptr];
               seg.x_from = turtle_x[depth_ptr];
               seg.y_from = turtle_y[depth_ptr];
               seg.x_to = 12'(moved_coord(turtle_x[depth_ptr],
                                          signed_sine((h + 1440) % 5760), regs.step_length));
               seg.y_to = 12'(moved_coord(turtle_y[depth_ptr], signed_sine(h),
                                          regs.step_length));
               seg.stroke = 16'((turtle_wid[depth_ptr] > regs.width_min) ?
                                turtle_wid[depth_ptr] : regs.width_min);
               turtle_x[depth_ptr] = seg.x_to;
               turtle_y[depth_ptr] = seg.y_to;
               turtle_wid[depth_ptr] = (turtle_wid[depth_ptr] > regs.width_decrement) ?
                                       turtle_wid[depth_ptr] - regs.width_decrement : 0;
               pending_segments.push_back(seg);
            end
            SYM_PLUS: turtle_head[depth_ptr] = (turtle_head[depth_ptr] + turn) % 5760;
            SYM_MINUS: turtle_head[depth_ptr] = (turtle_head[depth_ptr] + 5760 - turn) % 5760;
            SYM_PUSH: begin
               if (depth_ptr + 1 >= STACK_DEPTH) begin
                  stopped = 1;
                  seg.kind = KIND_OVERFLOW;
                  pending_segments.push_back(seg);
               end else begin
                  turtle_x[depth_ptr + 1] = turtle_x[depth_ptr];
                  turtle_y[depth_ptr + 1] = turtle_y[depth_ptr];
                  turtle_head[depth_ptr + 1] = turtle_head[depth_ptr];
                  turtle_wid[depth_ptr + 1] = turtle_wid[depth_ptr];
                  depth_ptr++;
               end
            end
            SYM_POP: begin
               if (depth_ptr == 0) begin
                  stopped = 1;
                  seg.kind = KIND_UNDERFLOW;
                  pending_segments.push_back(seg);
               end else begin
                  depth_ptr--;
               end
            end
            default: ;
         endcase
      end
   endtask

   // Sends one request; valid stays high between back-to-back requests.
   task automatic send_symbol(input logic [7:0] sym, input logic fresh);
      if (stalls_on && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sym;
      req_tuser <= fresh;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_symbol(sym, fresh);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes every register in one burst; the block must be idle.
   task automatic load_config(input cfg_type c);
      logic [15:0] vals [8];
      vals = '{{3'b000, c.angle_step}, {{3{c.start_angle[12]}}, c.start_angle},
               c.step_length, {4'b0000, c.start_x}, {4'b0000, c.start_y},
               c.width_start, c.width_decrement, c.width_min};
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      regs = c;
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      c.angle_step = 13'($urandom_range(5759));
      c.start_angle = 13'($signed($urandom_range(5760)) - 2880);
      c.step_length = 16'(($urandom_range(3) == 0) ? $urandom_range(65535) :
                                                     $urandom_range(4000));
      c.start_x = 12'($urandom_range(4095));
      c.start_y = 12'($urandom_range(4095));
      c.width_start = 16'($urandom_range(65535));
      c.width_decrement = 16'(($urandom_range(3) == 0) ? $urandom_range(65535) :
                                                         $urandom_range(50));
      c.width_min = 16'($urandom_range(65535));
      return c;
   endfunction

   task automatic test_directed;
      send_symbol(SYM_DRAW, 1'b1);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(SYM_PLUS, 1'b0);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(SYM_MINUS, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_MINUS, 1'b0);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(SYM_POP, 1'b0);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(SYM_POP, 1'b0);
      // Halted after the underflow: the draw and push below are ignored until a new word starts.
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(8'hFF, 1'b1);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(8'h00, 1'b1);
      send_symbol(SYM_POP, 1'b1);
      drain();
   endtask

   // Enough pushes to fill the stack and run past its top.
   task automatic test_stack_overflow;
      send_symbol(SYM_PUSH, 1'b1);
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
         if (i % 97 == 0) send_symbol(SYM_DRAW, 1'b0);
         send_symbol(SYM_PUSH, 1'b0);
      end
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_DRAW, 1'b0);
      send_symbol(SYM_DRAW, 1'b1);
      drain();
   endtask

   task automatic test_config_extremes;
      cfg_type c;
      for (int s = 0; s < 4; s++) begin
         c.angle_step = (s % 2) ? 13'd5759 : 13'd0;
         c.start_angle = (s < 2) ? -13'sd2880 : 13'sd2880;
         c.step_length = (s % 2) ? 16'hFFFF : 16'd0;
         c.start_x = (s < 2) ? 12'd0 : 12'd4095;
         c.start_y = (s % 3) ? 12'd4095 : 12'd0;
         c.width_start = (s % 2) ? 16'hFFFF : 16'd0;
         c.width_decrement = (s < 2) ? 16'hFFFF : 16'd1;
         c.width_min = (s == 1) ? 16'hFFFF : 16'd0;
         load_config(c);
         send_symbol(SYM_DRAW, 1'b1);
         for (int i = 0; i < 6; i++) begin
            send_symbol((i % 2) ? SYM_PLUS : SYM_MINUS, 1'b0);
            send_symbol(SYM_DRAW, 1'b0);
         end
         drain();
      end
   endtask

   task automatic test_random_words(input int phases, input int words);
      int          nesting;
      int          len;
      int          pick;
      logic [7:0]  sym;
      for (int p = 0; p < phases; p++) begin
         load_config(random_config());
         stalls_on = (p != 1);
         for (int w = 0; w < words; w++) begin
            len = $urandom_range(40, 4);
            nesting = 0;
            if (p == 2 && w == words / 2) drain();
            for (int i = 0; i < len; i++) begin
               pick = $urandom_range(99);
               if (pick < 36) sym = SYM_DRAW;
               else if (pick < 50) sym = SYM_PLUS;
               else if (pick < 64) sym = SYM_MINUS;
               else if (pick < 76) sym = (nesting < 30) ? SYM_PUSH : SYM_DRAW;
               else if (pick < 88) sym = (nesting > 0) ? SYM_POP : SYM_PLUS;
               else if (pick < 90) sym = SYM_POP;
               else sym = 8'($urandom_range(255));
               if (sym == SYM_PUSH) nesting++;
               if (sym == SYM_POP && nesting > 0) nesting--;
               send_symbol(sym, i == 0);
            end
         end
         drain();
      end
   endtask

   initial begin
      regs = '{13'd480, 13'd0, 16'd614, 12'd520, 12'd999, 16'd600, 16'd4, 16'd120};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_stack_overflow();
      test_config_extremes();
      test_random_words(8, 5);
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   // Result checker and random receiver stalls.
   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_segments.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result kind=%0d data=%h", rsp_tuser,
                                           rsp_tdata);
         end else begin
            want = pending_segments.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[11:0] !== want.x_from ||
                rsp_tdata[23:12] !== want.y_from || rsp_tdata[35:24] !== want.x_to ||
                rsp_tdata[47:36] !== want.y_to || rsp_tdata[63:48] !== want.stroke) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected kind=%0d from=(%0d,%0d) to=(%0d,%0d) w=%0d,",
                            " got kind=%0d from=(%0d,%0d) to=(%0d,%0d) w=%0d"},
                           want.kind, want.x_from, want.y_from, want.x_to, want.y_to,
                           want.stroke, rsp_tuser, rsp_tdata[11:0], rsp_tdata[23:12],
                           rsp_tdata[35:24], rsp_tdata[47:36], rsp_tdata[63:48]);
            end
         end
      end
      rsp_tready <= !reset && !(stalls_on && $urandom_range(99) < 16);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

>>> filelist.f
hdl/tbi_pkg.sv
hdl/tbi_front.sv
hdl/tbi_back.sv
hdl/turtle_branch_interpreter.sv
tb/sv/turtle_branch_interpreter_tb.sv
